/* src/crast_pkg.sv */
// crast_pkg: shared command codes and per-step point constants for the
// circle rasterizer. No dependencies.

package crast_pkg;

	// Input command codes
	typedef enum logic {
		CMD_START = 1'b0,
		CMD_STEP  = 1'b1
	} cmd_t;

	// Mirrored points emitted for one step
	localparam int PTS_PER_STEP = 8;
	localparam int PT_IDX_W     = 3;

endpackage

/* src/crast_front.sv */
// crast_front: accepts command words, holds the circle state and runs the
// midpoint error update, handing one job per active step to the job queue.
// Depends on crast_pkg.

module crast_front
	import crast_pkg::*;
#(
	parameter int COORD_BITS  = 16,
	parameter int RADIUS_BITS = 14,
	parameter int JOB_W       = 2 * (COORD_BITS - 1) + 2 * (RADIUS_BITS + 1) + 9
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic                          cmd,
	input  logic signed [COORD_BITS-2:0]  center_x,
	input  logic signed [COORD_BITS-2:0]  center_y,
	input  logic        [RADIUS_BITS-1:0] radius,
	input  logic        [7:0]             glyph,
	output logic                          job_wr,
	output logic        [JOB_W-1:0]       job_data,
	input  logic                          job_full
);

	localparam int CTR_W = COORD_BITS - 1;
	localparam int OFF_W = RADIUS_BITS + 1;
	localparam int ERR_W = RADIUS_BITS + 2;

	typedef struct packed {
		logic signed [CTR_W-1:0] cx;
		logic signed [CTR_W-1:0] cy;
		logic        [OFF_W-1:0] dx;
		logic        [OFF_W-1:0] dy;
		logic        [7:0]       glyph;
		logic                    fin;
	} job_t;

	logic signed [CTR_W-1:0] cx_q, cy_q;
	logic        [OFF_W-1:0] dx_q, dy_q;
	logic signed [ERR_W-1:0] err_q;
	logic        [7:0]       glyph_q;
	logic                    active_q;

	logic                    accept;
	logic                    is_step;
	logic                    err_pos;
	logic signed [ERR_W-1:0] dx_ext, dy_ext;
	logic signed [ERR_W-1:0] err_d;
	logic        [OFF_W-1:0] dy_d;
	logic        [OFF_W-1:0] dx_d;
	logic                    fin_d;
	job_t                    job;

	assign full    = job_full;
	assign accept  = push && !full;
	assign is_step = (cmd_t'(cmd) == CMD_STEP);

	// Midpoint error update for the current offsets
	assign dx_ext  = ERR_W'(dx_q);
	assign dy_ext  = ERR_W'(dy_q);
	assign err_pos = (err_q > 0);
	assign err_d   = err_pos ? (err_q + dx_ext - dy_ext) : (err_q + dx_ext);
	assign dy_d    = err_pos ? (dy_q - OFF_W'(1)) : dy_q;
	assign dx_d    = dx_q + OFF_W'(1);
	// dx + 1 > new dy is the same as dx >= new dy
	assign fin_d   = (dx_q >= dy_d);

	// Job word carries the pre-update offsets
	always_comb begin
		job.cx    = cx_q;
		job.cy    = cy_q;
		job.dx    = dx_q;
		job.dy    = dy_q;
		job.glyph = glyph_q;
		job.fin   = fin_d;
	end

	assign job_data = job;
	assign job_wr   = accept && is_step && active_q;

	// Load on start, advance on active step, drop idle steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q     <= '0;
			cy_q     <= '0;
			dx_q     <= '0;
			dy_q     <= '0;
			err_q    <= '0;
			glyph_q  <= '0;
			active_q <= 1'b0;
		end else if (accept) begin
			if (!is_step) begin
				cx_q     <= center_x;
				cy_q     <= center_y;
				dx_q     <= '0;
				dy_q     <= OFF_W'(radius);
				err_q    <= '0;
				glyph_q  <= glyph;
				active_q <= 1'b1;
			end else if (active_q) begin
				dx_q  <= dx_d;
				dy_q  <= dy_d;
				err_q <= err_d;
				if (fin_d) begin
					active_q <= 1'b0;
				end
			end
		end
	end

endmodule

/* src/crast_jobq.sv */
// crast_jobq: two-entry job queue between the front and the point
// generator. No dependencies.

module crast_jobq #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	output logic             rd_valid,
	output logic [WIDTH-1:0] rd_data,
	input  logic             rd_en
);

	localparam logic [1:0] DEPTH = 2'd2;

	logic [WIDTH-1:0] slot_q [2];
	logic             wr_ptr_q, rd_ptr_q;
	logic [1:0]       count_q;
	logic             do_wr, do_rd;

	assign full     = (count_q == DEPTH);
	assign rd_valid = (count_q != 2'd0);
	assign rd_data  = slot_q[rd_ptr_q];
	assign do_wr    = wr_en && !full;
	assign do_rd    = rd_en && rd_valid;

	// Store incoming word
	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_rd) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			unique case ({do_wr, do_rd})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* src/crast_back.sv */
// crast_back: point generator. Walks the eight mirrored points of the job at
// the queue head, one per cycle while pop is high, into the result register.
// Depends on crast_pkg.

module crast_back
	import crast_pkg::*;
#(
	parameter int COORD_BITS  = 16,
	parameter int RADIUS_BITS = 14,
	parameter int JOB_W       = 2 * (COORD_BITS - 1) + 2 * (RADIUS_BITS + 1) + 9
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         job_valid,
	input  logic        [JOB_W-1:0]      job_data,
	output logic                         job_rd,
	output logic                         empty,
	input  logic                         pop,
	output logic signed [COORD_BITS-1:0] point_x,
	output logic signed [COORD_BITS-1:0] point_y,
	output logic        [7:0]            point_glyph,
	output logic                         last,
	output logic                         finished
);

	localparam int CTR_W = COORD_BITS - 1;
	localparam int OFF_W = RADIUS_BITS + 1;
	localparam int SUM_W = COORD_BITS + OFF_W;

	typedef struct packed {
		logic signed [CTR_W-1:0] cx;
		logic signed [CTR_W-1:0] cy;
		logic        [OFF_W-1:0] dx;
		logic        [OFF_W-1:0] dy;
		logic        [7:0]       glyph;
		logic                    fin;
	} job_t;

	job_t                job;
	logic [PT_IDX_W-1:0] idx_q;
	logic                valid_q;
	logic                load;
	logic                emit;
	logic                is_last;
	logic [OFF_W-1:0]    off_a, off_b;
	logic [SUM_W-1:0]    cx_ext, cy_ext, a_ext, b_ext;
	logic [SUM_W-1:0]    px, py;

	assign job     = job_t'(job_data);
	assign empty   = !valid_q;
	assign load    = !valid_q || pop;
	assign emit    = load && job_valid;
	assign is_last = (idx_q == PT_IDX_W'(PTS_PER_STEP - 1));
	assign job_rd  = emit && is_last;

	// Select mirror: upper half swaps dx and dy, low bits pick the signs
	assign off_a  = idx_q[2] ? job.dy : job.dx;
	assign off_b  = idx_q[2] ? job.dx : job.dy;
	assign cx_ext = {{(SUM_W - CTR_W){job.cx[CTR_W-1]}}, job.cx};
	assign cy_ext = {{(SUM_W - CTR_W){job.cy[CTR_W-1]}}, job.cy};
	assign a_ext  = {{(SUM_W - OFF_W){1'b0}}, off_a};
	assign b_ext  = {{(SUM_W - OFF_W){1'b0}}, off_b};
	assign px     = idx_q[0] ? (cx_ext - a_ext) : (cx_ext + a_ext);
	assign py     = idx_q[1] ? (cy_ext - b_ext) : (cy_ext + b_ext);

	// Hold result word until popped, refill from the queue head
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= 1'b0;
			idx_q       <= '0;
			point_x     <= '0;
			point_y     <= '0;
			point_glyph <= '0;
			last        <= 1'b0;
			finished    <= 1'b0;
		end else if (load) begin
			valid_q <= job_valid;
			if (job_valid) begin
				point_x     <= px[COORD_BITS-1:0];
				point_y     <= py[COORD_BITS-1:0];
				point_glyph <= job.glyph;
				last        <= is_last;
				finished    <= job.fin;
				idx_q       <= idx_q + PT_IDX_W'(1);
			end
		end
	end

endmodule

/* src/circle_rasterizer_unit.sv */
// circle_rasterizer_unit: top level of the midpoint circle rasterizer.
// Depends on crast_pkg, crast_front, crast_jobq and crast_back.

// Midpoint circle rasterizer. Push a start word (cmd 0) with center, radius
// and glyph, then push step words (cmd 1); each step on an active circle
// yields eight mirrored point words, the eighth marked last, all eight
// marked finished on the circle's final step. A start produces nothing; a
// step while idle is dropped. The front updates the error term in the cycle
// a word is accepted and queues up to two steps; the point generator emits
// one point per cycle while pop stays high and starts a step only after the
// previous step's eighth point. The first point of a step passes through the
// job queue and then the result register.

module circle_rasterizer_unit
	import crast_pkg::*;
#(
	parameter int COORD_BITS  = 16,
	parameter int RADIUS_BITS = 14
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic                          cmd,
	input  logic signed [COORD_BITS-2:0]  center_x,
	input  logic signed [COORD_BITS-2:0]  center_y,
	input  logic        [RADIUS_BITS-1:0] radius,
	input  logic        [7:0]             glyph,
	output logic                          empty,
	input  logic                          pop,
	output logic signed [COORD_BITS-1:0]  point_x,
	output logic signed [COORD_BITS-1:0]  point_y,
	output logic        [7:0]             point_glyph,
	output logic                          last,
	output logic                          finished
);

	localparam int JOB_W = 2 * (COORD_BITS - 1) + 2 * (RADIUS_BITS + 1) + 9;

	logic             job_wr, job_full, job_valid, job_rd;
	logic [JOB_W-1:0] job_wdata, job_rdata;

	crast_front #(
		.COORD_BITS  (COORD_BITS),
		.RADIUS_BITS (RADIUS_BITS),
		.JOB_W       (JOB_W)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.cmd      (cmd),
		.center_x (center_x),
		.center_y (center_y),
		.radius   (radius),
		.glyph    (glyph),
		.job_wr   (job_wr),
		.job_data (job_wdata),
		.job_full (job_full)
	);

	crast_jobq #(
		.WIDTH (JOB_W)
	) u_jobq (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (job_wr),
		.wr_data  (job_wdata),
		.full     (job_full),
		.rd_valid (job_valid),
		.rd_data  (job_rdata),
		.rd_en    (job_rd)
	);

	crast_back #(
		.COORD_BITS  (COORD_BITS),
		.RADIUS_BITS (RADIUS_BITS),
		.JOB_W       (JOB_W)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.job_valid   (job_valid),
		.job_data    (job_rdata),
		.job_rd      (job_rd),
		.empty       (empty),
		.pop         (pop),
		.point_x     (point_x),
		.point_y     (point_y),
		.point_glyph (point_glyph),
		.last        (last),
		.finished    (finished)
	);

endmodule

/* src/crast_checker.sv */
// crast_checker: port-level checks on circle_rasterizer_unit, bound to the
// top level. Depends on circle_rasterizer_unit.

module crast_checker #(
	parameter int COORD_BITS = 16
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  push,
	input logic                  full,
	input logic                  empty,
	input logic                  pop,
	input logic [COORD_BITS-1:0] point_x,
	input logic [COORD_BITS-1:0] point_y,
	input logic [7:0]            point_glyph,
	input logic                  last,
	input logic                  finished
);

	// Waiting word holds while not popped
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(point_x) && $stable(point_y)
			&& $stable(point_glyph) && $stable(last) && $stable(finished)))
		else $error("result word changed while waiting");

	// Within a step the next point follows at once
	a_burst: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !empty && !last) |=> !empty)
		else $error("gap inside a step");

	// Glyph and final mark are shared by all points of a step
	a_same_step: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !empty && !last) |=>
			(point_glyph == $past(point_glyph) && finished == $past(finished)))
		else $error("step attributes changed mid-step");

	// Queue fills only through a push
	a_full_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(full) |-> $past(push))
		else $error("full rose without a push");

endmodule

bind circle_rasterizer_unit crast_checker #(
	.COORD_BITS (COORD_BITS)
) u_crast_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.push        (push),
	.full        (full),
	.empty       (empty),
	.pop         (pop),
	.point_x     (point_x),
	.point_y     (point_y),
	.point_glyph (point_glyph),
	.last        (last),
	.finished    (finished)
);
